// File: hw/rtl/dhm_pkg.sv
// shared types, codes and the zone table of the dart hit matrix scanner
package dhm_pkg;

  localparam int LINES_W = 16;
  localparam int MIC_W = 10;
  localparam int DRIVE_W = 2;
  localparam int KIND_W = 2;
  localparam int ZONE_W = 6;
  localparam int LINE_IDX_W = 4;
  localparam int CNT_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TABLE_SIZE = 62;

  localparam logic [KIND_W-1:0] EV_NONE = 2'd0;
  localparam logic [KIND_W-1:0] EV_HIT = 2'd1;
  localparam logic [KIND_W-1:0] EV_MISS = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MISS_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_TICKS = 2'd2;

  localparam logic [MIC_W-1:0] MISS_THRESHOLD_RST = 10'd512;
  localparam logic [CNT_W-1:0] DEBOUNCE_TICKS_RST = 16'd300;
  localparam logic [CNT_W-1:0] LOCKOUT_TICKS_RST = 16'd300;

  // entry = common * 32 + line, order sets priority
  localparam logic [7:0] ZONE_TABLE [TABLE_SIZE] = '{
    8'd0, 8'd7, 8'd6, 8'd1, 8'd9, 8'd8, 8'd2, 8'd11, 8'd10,
    8'd3, 8'd13, 8'd12, 8'd4, 8'd14, 8'd15,
    8'd33, 8'd41, 8'd40, 8'd34, 8'd43, 8'd42, 8'd35, 8'd45, 8'd44,
    8'd36, 8'd46, 8'd47, 8'd37, 8'd32, 8'd39, 8'd38,
    8'd64, 8'd71, 8'd70, 8'd66, 8'd75, 8'd74, 8'd67, 8'd77, 8'd76,
    8'd65, 8'd73, 8'd72, 8'd68, 8'd78, 8'd79,
    8'd96, 8'd103, 8'd102, 8'd97, 8'd105, 8'd104, 8'd98, 8'd107, 8'd106,
    8'd99, 8'd109, 8'd108, 8'd100, 8'd110, 8'd101, 8'd111
  };

  typedef struct packed {
    logic [MIC_W-1:0] miss_threshold;
    logic [CNT_W-1:0] debounce_ticks;
    logic [CNT_W-1:0] lockout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive_common;
    logic [KIND_W-1:0] event_kind;
    logic [ZONE_W-1:0] zone_index;
  } result_t;

  typedef struct packed {
    logic hit;
    logic [ZONE_W-1:0] zone;
    logic [LINE_IDX_W-1:0] line;
  } zone_hit_t;

endpackage

// File: hw/rtl/dhm_if.sv
// channel interfaces: tick input, result output and register write port
interface dhm_in_if;
  import dhm_pkg::*;
  logic valid;
  logic ready;
  logic [LINES_W-1:0] return_lines;
  logic [MIC_W-1:0] mic_sample;
  modport source (output valid, return_lines, mic_sample, input ready);
  modport sink (input valid, return_lines, mic_sample, output ready);
endinterface

interface dhm_out_if;
  import dhm_pkg::*;
  logic valid;
  logic ready;
  logic [DRIVE_W-1:0] drive_common;
  logic [KIND_W-1:0] event_kind;
  logic [ZONE_W-1:0] zone_index;
  modport source (output valid, drive_common, event_kind, zone_index, input ready);
  modport sink (input valid, drive_common, event_kind, zone_index, output ready);
endinterface

interface dhm_cfg_if;
  import dhm_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/dhm_zone_find.sv
// priority search of the zone table for a closed contact on the scanned common
module dhm_zone_find #(
  parameter int COMMON_COUNT = 4,
  parameter int LINE_COUNT = 16,
  parameter int ZONE_COUNT = 62,
  parameter int CW = 2
) (
  input  logic [CW-1:0]                   scan_common,
  input  logic [dhm_pkg::LINES_W-1:0]     return_lines,
  output dhm_pkg::zone_hit_t              find
);
  import dhm_pkg::*;

  always_comb begin
    logic [7:0] ent;
    logic [2:0] c;
    logic [4:0] l;
    find = '0;
    for (int k = TABLE_SIZE - 1; k >= 0; k--) begin
      ent = ZONE_TABLE[k];
      c = ent[7:5];
      l = ent[4:0];
      if (k < ZONE_COUNT && 8'(c) == 8'(scan_common) && int'(c) < COMMON_COUNT &&
          int'(l) < LINE_COUNT && l < 5'd16 && !return_lines[l[3:0]]) begin
        find.hit = 1'b1;
        find.zone = ZONE_W'(k);
        find.line = l[3:0];
      end
    end
  end

endmodule

// File: hw/rtl/dhm_tick_engine.sv
// scan, debounce and miss state with the per-tick next-state logic
module dhm_tick_engine #(
  parameter int COMMON_COUNT = 4,
  parameter int LINE_COUNT = 16,
  parameter int ZONE_COUNT = 62,
  parameter int MIC_AVERAGE = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [dhm_pkg::LINES_W-1:0]   return_lines,
  input  logic [dhm_pkg::MIC_W-1:0]     mic_sample,
  input  dhm_pkg::cfg_t                 cfg,
  output dhm_pkg::result_t              res
);
  import dhm_pkg::*;

  localparam int CW = (COMMON_COUNT > 1) ? $clog2(COMMON_COUNT) : 1;
  localparam int HIST_N = (MIC_AVERAGE > 1) ? MIC_AVERAGE - 1 : 1;
  localparam int SUM_W = MIC_W + $clog2(MIC_AVERAGE) + 1;
  localparam logic [CW-1:0] LAST_COMMON = CW'(COMMON_COUNT - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [1:0] PH_SCAN = 2'd0;
  localparam logic [1:0] PH_DEB1 = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;
  localparam logic [1:0] PH_DEB2 = 2'd3;

  logic [CW-1:0] scan_common_r, scan_common_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [CNT_W-1:0] hold_count_r, hold_count_nxt;
  logic [ZONE_W-1:0] held_zone_r, held_zone_nxt;
  logic [LINE_IDX_W-1:0] held_line_r, held_line_nxt;
  logic [MIC_W-1:0] hist_r [HIST_N];
  logic [MIC_W-1:0] hist_nxt [HIST_N];
  logic [CNT_W-1:0] tsm_r, tsm_nxt;

  zone_hit_t find;
  logic [CNT_W-1:0] tsm_inc, cnt_inc;
  logic cnt_done;
  logic [SUM_W-1:0] mic_sum, thr_lim;
  logic avg_over;

  dhm_zone_find #(
    .COMMON_COUNT(COMMON_COUNT),
    .LINE_COUNT(LINE_COUNT),
    .ZONE_COUNT(ZONE_COUNT),
    .CW(CW)
  ) u_find (
    .scan_common(scan_common_r),
    .return_lines(return_lines),
    .find(find)
  );

  assign tsm_inc = (tsm_r != CNT_MAX) ? tsm_r + 1'b1 : tsm_r;
  assign cnt_inc = (hold_count_r != CNT_MAX) ? hold_count_r + 1'b1 : hold_count_r;
  assign cnt_done = cnt_inc >= cfg.debounce_ticks;

  // floor(sum / n) > t  is  sum >= (t + 1) * n
  always_comb begin
    mic_sum = SUM_W'(mic_sample);
    for (int k = 0; k < MIC_AVERAGE - 1; k++) begin
      mic_sum = mic_sum + SUM_W'(hist_r[k]);
    end
  end
  assign thr_lim = (SUM_W'(cfg.miss_threshold) + 1'b1) * SUM_W'(MIC_AVERAGE);
  assign avg_over = mic_sum >= thr_lim;

  always_comb begin
    scan_common_nxt = scan_common_r;
    phase_nxt = phase_r;
    hold_count_nxt = hold_count_r;
    held_zone_nxt = held_zone_r;
    held_line_nxt = held_line_r;
    tsm_nxt = tsm_inc;
    res.event_kind = EV_NONE;
    res.zone_index = '0;
    case (phase_r)
      PH_SCAN: begin
        if (find.hit) begin
          phase_nxt = PH_DEB1;
          hold_count_nxt = '0;
          held_zone_nxt = find.zone;
          held_line_nxt = find.line;
        end else if (scan_common_r == LAST_COMMON) begin
          if (avg_over && tsm_inc > cfg.lockout_ticks) begin
            res.event_kind = EV_MISS;
            tsm_nxt = '0;
          end
          scan_common_nxt = '0;
        end else begin
          scan_common_nxt = scan_common_r + 1'b1;
        end
      end
      PH_DEB1: begin
        hold_count_nxt = cnt_inc;
        if (cnt_done) begin
          phase_nxt = PH_WAIT;
          hold_count_nxt = '0;
        end
      end
      PH_WAIT: begin
        if (return_lines[held_line_r]) begin
          phase_nxt = PH_DEB2;
          hold_count_nxt = '0;
        end
      end
      default: begin
        hold_count_nxt = cnt_inc;
        if (cnt_done) begin
          res.event_kind = EV_HIT;
          res.zone_index = held_zone_r;
          phase_nxt = PH_SCAN;
          hold_count_nxt = '0;
          scan_common_nxt = '0;
        end
      end
    endcase
    res.drive_common = DRIVE_W'(scan_common_nxt);
  end

  always_comb begin
    hist_nxt[0] = mic_sample;
    for (int k = 1; k < HIST_N; k++) begin
      hist_nxt[k] = hist_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_common_r <= '0;
      phase_r <= PH_SCAN;
      hold_count_r <= '0;
      held_zone_r <= '0;
      held_line_r <= '0;
      tsm_r <= '0;
      for (int k = 0; k < HIST_N; k++) begin
        hist_r[k] <= '0;
      end
    end else if (en) begin
      scan_common_r <= scan_common_nxt;
      phase_r <= phase_nxt;
      hold_count_r <= hold_count_nxt;
      held_zone_r <= held_zone_nxt;
      held_line_r <= held_line_nxt;
      tsm_r <= tsm_nxt;
      hist_r <= hist_nxt;
    end
  end

`ifndef SYNTH
  a_wait_exit: assert property (@(posedge clk) disable iff (!rst_n)
    en && phase_r == PH_WAIT |=> phase_r == PH_WAIT || phase_r == PH_DEB2)
    else $error("release wait left to an unexpected phase");
  a_hit_from_deb2: assert property (@(posedge clk) disable iff (!rst_n)
    en && res.event_kind == EV_HIT |-> phase_r == PH_DEB2)
    else $error("hit reported outside second debounce");
  a_miss_clears: assert property (@(posedge clk) disable iff (!rst_n)
    en && res.event_kind == EV_MISS |=> tsm_r == '0)
    else $error("miss did not restart the lockout counter");
  a_hold_common: assert property (@(posedge clk) disable iff (!rst_n)
    en && (phase_r == PH_DEB1 || phase_r == PH_WAIT) |=> $stable(scan_common_r))
    else $error("scanned common moved while a hit is held");
`endif

endmodule

// File: hw/rtl/dart_hit_matrix_and_miss_detector.sv
// dart board hit matrix scanner and miss detector, top level
//
// in_chan carries one tick: the 16 active-low return lines sampled while the
// previous common was driven, and the microphone sample of that tick.
// out_chan gives exactly one result per tick: the common to drive next, the
// event kind (none, target hit, miss) and the zone index of a hit.
// cfg_chan writes miss_threshold (0), debounce_ticks (1), lockout_ticks (2);
// it is always ready and writes to other indexes are dropped.
// a tick is taken into an input register, the scan/debounce/miss logic runs
// between that register and the output register, which drives out_chan.valid,
// and one tick per cycle is sustained while out_chan does not stall.
// when out_chan stalls the output register holds its result, the input
// register still takes one more tick, and then in_chan.ready drops.
// synchronous reset clears all scan state, the microphone history and the
// lockout counter and loads the register defaults (512, 300, 300).
module dart_hit_matrix_and_miss_detector #(
  parameter int COMMON_COUNT = 4,
  parameter int LINE_COUNT = 16,
  parameter int ZONE_COUNT = 62,
  parameter int MIC_AVERAGE = 3
) (
  input  logic         clk,
  input  logic         rst_n,
  dhm_in_if.sink       in_chan,
  dhm_out_if.source    out_chan,
  dhm_cfg_if.sink      cfg_chan
);
  import dhm_pkg::*;

  logic s1_valid_r;
  logic [LINES_W-1:0] s1_lines_r;
  logic [MIC_W-1:0] s1_mic_r;
  logic out_valid_r;
  result_t out_res_r;
  result_t res;
  cfg_t cfg_r;
  logic adv, en, in_xfer;

  assign adv = !out_valid_r || out_chan.ready;
  assign en = s1_valid_r && adv;
  assign in_chan.ready = !s1_valid_r || adv;
  assign in_xfer = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_lines_r <= in_chan.return_lines;
      s1_mic_r <= in_chan.mic_sample;
    end
    if (en) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.miss_threshold <= MISS_THRESHOLD_RST;
      cfg_r.debounce_ticks <= DEBOUNCE_TICKS_RST;
      cfg_r.lockout_ticks <= LOCKOUT_TICKS_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_MISS_THRESHOLD: cfg_r.miss_threshold <= cfg_chan.data[MIC_W-1:0];
        CFG_DEBOUNCE_TICKS: cfg_r.debounce_ticks <= cfg_chan.data;
        CFG_LOCKOUT_TICKS: cfg_r.lockout_ticks <= cfg_chan.data;
        default: begin
        end
      endcase
    end
  end

  dhm_tick_engine #(
    .COMMON_COUNT(COMMON_COUNT),
    .LINE_COUNT(LINE_COUNT),
    .ZONE_COUNT(ZONE_COUNT),
    .MIC_AVERAGE(MIC_AVERAGE)
  ) u_engine (
    .clk(clk),
    .rst_n(rst_n),
    .en(en),
    .return_lines(s1_lines_r),
    .mic_sample(s1_mic_r),
    .cfg(cfg_r),
    .res(res)
  );

  assign out_chan.valid = out_valid_r;
  assign out_chan.drive_common = out_res_r.drive_common;
  assign out_chan.event_kind = out_res_r.event_kind;
  assign out_chan.zone_index = out_res_r.zone_index;

endmodule

// File: tb/dhm_scan_checker.sv
// checker for the dart hit matrix scanner: predicts every tick result and compares transfers
`timescale 1ns / 100ps

module dhm_scan_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [dhm_pkg::LINES_W-1:0]    in_lines,
  input  logic [dhm_pkg::MIC_W-1:0]      in_mic,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [dhm_pkg::DRIVE_W-1:0]    out_drive,
  input  logic [dhm_pkg::KIND_W-1:0]     out_kind,
  input  logic [dhm_pkg::ZONE_W-1:0]     out_zone,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [dhm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dhm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import dhm_pkg::*;

  localparam int NUM_COMMONS = 4;
  localparam int NUM_ZONES = 62;
  localparam int MIC_TAPS = 3;

  // common * 32 + line, earlier entries win
  localparam logic [7:0] ZONE_MAP [NUM_ZONES] = '{
    8'h00, 8'h07, 8'h06, 8'h01, 8'h09, 8'h08, 8'h02, 8'h0B, 8'h0A,
    8'h03, 8'h0D, 8'h0C, 8'h04, 8'h0E, 8'h0F,
    8'h21, 8'h29, 8'h28, 8'h22, 8'h2B, 8'h2A, 8'h23, 8'h2D, 8'h2C,
    8'h24, 8'h2E, 8'h2F, 8'h25, 8'h20, 8'h27, 8'h26,
    8'h40, 8'h47, 8'h46, 8'h42, 8'h4B, 8'h4A, 8'h43, 8'h4D, 8'h4C,
    8'h41, 8'h49, 8'h48, 8'h44, 8'h4E, 8'h4F,
    8'h60, 8'h67, 8'h66, 8'h61, 8'h69, 8'h68, 8'h62, 8'h6B, 8'h6A,
    8'h63, 8'h6D, 8'h6C, 8'h64, 8'h6E, 8'h65, 8'h6F
  };

  typedef enum logic [1:0] {PH_SCAN, PH_DEBOUNCE1, PH_RELEASE, PH_DEBOUNCE2} scan_phase_t;

  logic [MIC_W-1:0]      thr_q;
  logic [CNT_W-1:0]      debounce_q;
  logic [CNT_W-1:0]      lockout_q;
  logic [DRIVE_W-1:0]    cur_common;
  scan_phase_t           ph;
  logic [CNT_W-1:0]      hold_cnt;
  logic [ZONE_W-1:0]     zone_held;
  logic [LINE_IDX_W-1:0] line_held;
  logic [MIC_W-1:0]      mic_hist [2];
  logic [CNT_W-1:0]      since_miss;
  result_t               predicted_events [$];

  function automatic logic debounce_step();
    if (hold_cnt != '1) hold_cnt++;
    return hold_cnt >= debounce_q;
  endfunction

  function automatic result_t score_tick(input logic [LINES_W-1:0] lines,
                                         input logic [MIC_W-1:0] mic);
    result_t r;
    logic [11:0] mic_sum;
    logic found;
    int k;
    r = '0;
    found = 1'b0;
    if (since_miss != '1) since_miss++;
    mic_sum = 12'(mic) + 12'(mic_hist[0]) + 12'(mic_hist[1]);
    case (ph)
      PH_SCAN: begin
        for (k = 0; k < NUM_ZONES; k++) begin
          if (!found && ZONE_MAP[k][7:5] == 3'(cur_common) && ZONE_MAP[k][4:0] < 5'd16 &&
              !lines[ZONE_MAP[k][3:0]]) begin
            found = 1'b1;
            zone_held = ZONE_W'(k);
            line_held = ZONE_MAP[k][3:0];
          end
        end
        if (found) begin
          ph = PH_DEBOUNCE1;
          hold_cnt = '0;
        end else if (int'(cur_common) + 1 >= NUM_COMMONS) begin
          if (int'(mic_sum) / MIC_TAPS > int'(thr_q) && since_miss > lockout_q) begin
            r.event_kind = EV_MISS;
            since_miss = '0;
          end
          cur_common = '0;
        end else begin
          cur_common++;
        end
      end
      PH_DEBOUNCE1: begin
        if (debounce_step()) begin
          ph = PH_RELEASE;
          hold_cnt = '0;
        end
      end
      PH_RELEASE: begin
        if (lines[line_held]) begin
          ph = PH_DEBOUNCE2;
          hold_cnt = '0;
        end
      end
      default: begin
        if (debounce_step()) begin
          r.event_kind = EV_HIT;
          r.zone_index = zone_held;
          ph = PH_SCAN;
          hold_cnt = '0;
          cur_common = '0;
        end
      end
    endcase
    mic_hist[1] = mic_hist[0];
    mic_hist[0] = mic;
    r.drive_common = cur_common;
    return r;
  endfunction

  task automatic flag(input string what, input int want, input int got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      thr_q = MISS_THRESHOLD_RST;
      debounce_q = DEBOUNCE_TICKS_RST;
      lockout_q = LOCKOUT_TICKS_RST;
      cur_common = '0;
      ph = PH_SCAN;
      hold_cnt = '0;
      zone_held = '0;
      line_held = '0;
      mic_hist[0] = '0;
      mic_hist[1] = '0;
      since_miss = '0;
      predicted_events.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MISS_THRESHOLD: thr_q = cfg_data[MIC_W-1:0];
          CFG_DEBOUNCE_TICKS: debounce_q = cfg_data;
          CFG_LOCKOUT_TICKS: lockout_q = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (predicted_events.size() == 0) begin
          flag("unexpected result event_kind", -1, int'(out_kind));
        end else begin
          want = predicted_events.pop_front();
          if (want.drive_common !== out_drive)
            flag("drive_common", int'(want.drive_common), int'(out_drive));
          if (want.event_kind !== out_kind)
            flag("event_kind", int'(want.event_kind), int'(out_kind));
          if (want.zone_index !== out_zone)
            flag("zone_index", int'(want.zone_index), int'(out_zone));
        end
      end
      if (in_valid && in_ready) predicted_events.push_back(score_tick(in_lines, in_mic));
    end
    pending = predicted_events.size();
  end

endmodule

// File: tb/dart_hit_matrix_and_miss_detector_tb.sv
// testbench top for the dart hit matrix scanner: tick stimulus, register writes, stalls, verdict
`timescale 1ns / 100ps

module dart_hit_matrix_and_miss_detector_tb;
  import dhm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   ticks_sent = 0;
  int   idle_cycles = 0;
  int   cur_thr = 512;
  bit   no_idle = 1'b0;
  bit   hold_off_req = 1'b0;

  dhm_in_if  in_chan ();
  dhm_out_if out_chan ();
  dhm_cfg_if cfg_chan ();

  dart_hit_matrix_and_miss_detector dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  dhm_scan_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_lines   (in_chan.return_lines),
    .in_mic     (in_chan.mic_sample),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_drive  (out_chan.drive_common),
    .out_kind   (out_chan.event_kind),
    .out_zone   (out_chan.zone_index),
    .cfg_valid  (cfg_chan.valid),
    .cfg_ready  (cfg_chan.ready),
    .cfg_index  (cfg_chan.index),
    .cfg_data   (cfg_chan.data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  function automatic logic [MIC_W-1:0] pick_mic();
    case ($urandom_range(0, 3))
      0: return MIC_W'($urandom_range(0, 1023));
      1: return MIC_W'($urandom_range(cur_thr, 1023));
      2: return MIC_W'($urandom_range(0, cur_thr));
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  task automatic send_tick(input logic [LINES_W-1:0] lines, input logic [MIC_W-1:0] mic);
    while (!no_idle && $urandom_range(0, 99) < 7) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.return_lines <= lines;
    in_chan.mic_sample <= mic;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    ticks_sent++;
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
  endtask

  task automatic set_config(input int thr, input int deb, input int lock, input bit spare);
    drain();
    write_reg(CFG_MISS_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(CFG_DEBOUNCE_TICKS, CFG_DATA_W'(deb));
    write_reg(CFG_LOCKOUT_TICKS, CFG_DATA_W'(lock));
    if (spare) write_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 65535)));
    cfg_chan.valid <= 1'b0;
    cur_thr = thr;
  endtask

  // press, maybe bounce, then release
  task automatic throw_dart(input int settle);
    logic [LINES_W-1:0] contact;
    contact = '1;
    repeat ($urandom_range(1, 3)) contact[4'($urandom_range(0, 15))] = 1'b0;
    if ($urandom_range(0, 9) == 0) contact = LINES_W'($urandom_range(0, 65535));
    repeat ($urandom_range(1, settle + 6)) send_tick(contact, pick_mic());
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_tick(LINES_W'($urandom_range(0, 65535)), pick_mic());
    repeat ($urandom_range(1, settle + 10)) send_tick('1, pick_mic());
  endtask

  task automatic random_phase(input int thr, input int deb, input int lock, input int ticks,
                              input bit spare, input bit stall);
    int target;
    set_config(thr, deb, lock, spare);
    if (stall) hold_off_req = 1'b1;
    target = ticks_sent + ticks;
    while (ticks_sent < target) throw_dart(deb);
  endtask

  // output side stalls
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= no_idle || $urandom_range(0, 99) >= 7;
      end
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    in_chan.valid = 1'b0;
    in_chan.return_lines = '1;
    in_chan.mic_sample = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = CFG_MISS_THRESHOLD;
    cfg_chan.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults: loud but inside lockout
    repeat (4) send_tick('1, '1);

    set_config(0, 0, 0, 1'b0);
    repeat (4) send_tick('1, '0);
    repeat (4) send_tick('1, '1);
    repeat (2) send_tick('1, 10'd1);
    send_tick(16'h0000, '1);
    send_tick(16'h0000, '0);
    send_tick(16'h0000, '0);
    repeat (2) send_tick('1, '0);
    send_tick(16'h7FFF, 10'd512);
    repeat (3) send_tick('1, 10'd513);
    send_tick(16'hFFDF, '0);
    send_tick(16'hFFDF, '0);
    repeat (3) send_tick('1, 10'd600);

    random_phase(600, 2, 12, 400, 1'b0, 1'b0);
    random_phase(1023, 1, 65535, 350, 1'b0, 1'b1);
    no_idle = 1'b1;
    random_phase(0, 0, 0, 350, 1'b0, 1'b0);
    no_idle = 1'b0;
    random_phase($urandom_range(0, 1023), $urandom_range(0, 6), $urandom_range(0, 40), 400,
                 1'b0, 1'b0);
    random_phase(300, 4, 3, 350, 1'b1, 1'b0);

    in_chan.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
